// ----- hdl/newton_cube_root_top_macros.svh -----
// Assertion macros for the cube root block.
// Used by newton_cube_root_top; no other dependencies.
`ifndef NEWTON_CUBE_ROOT_TOP_MACROS_SVH
`define NEWTON_CUBE_ROOT_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define NCR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define NCR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define NCR_ASSERT_NOW(label, ante, cons)
`define NCR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hdl/ncr_pkg.sv -----
// Shared constants, types and codes for the cube root block.
// No dependencies.
`timescale 1ns / 1ps
package ncr_pkg;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int TOL_W     = 31;
    localparam int LIM_W     = 8;
    localparam int STEP_W    = 9;
    localparam int A2_W      = 2 * DATA_W - FRAC_BITS - 1;   // |a|^2 >> FRAC_BITS
    localparam int A2_LO_W   = DATA_W;
    localparam int A2_HI_W   = A2_W - DATA_W;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ERR_W     = 64;
    localparam int NUM_W     = ERR_W + FRAC_BITS;
    localparam int DEN_W     = A2_W + 2;
    localparam int CNT_W     = $clog2(NUM_W + 1);
    localparam int NA_W      = 43;
    localparam int CAP_BIT   = 40;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 1'b1;

    localparam logic [1:0] STOP_TOL   = 2'd0;
    localparam logic [1:0] STOP_LIMIT = 2'd1;
    localparam logic [1:0] STOP_FAULT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_LO,
        ST_HI,
        ST_SUM,
        ST_CHECK,
        ST_DIV,
        ST_UPD,
        ST_DONE
    } state_t;
endpackage

// ----- hdl/newton_cube_root_top.sv -----
// Cube root of a signed Q16.16 word by Newton-Raphson iteration.
// A zero input goes straight to the result. Otherwise each update squares, cubes and checks
// the estimate, runs the bit-serial divider and updates the estimate; a final square, cube
// and check come before the result handshake.
// One word at a time: a new word is taken only in idle, after the result handshake; the divider sets the update time.
// Reset (rst_n, async low) returns to idle with tolerance 66 and iteration limit 20.
`timescale 1ns / 1ps
`include "newton_cube_root_top_macros.svh"
module newton_cube_root_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [ncr_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [ncr_pkg::DATA_W-1:0] root,
    output logic [ncr_pkg::STEP_W-1:0]        steps_taken,
    output logic [1:0]                        stop_reason,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ncr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ncr_pkg::TOL_W-1:0]         cfg_data
);
    ncr_pkg::state_t state_reg, state_next;

    logic [ncr_pkg::TOL_W-1:0]         tol_reg;
    logic [ncr_pkg::LIM_W-1:0]         lim_reg;
    logic signed [ncr_pkg::DATA_W-1:0] x_reg, x_next;
    logic signed [ncr_pkg::DATA_W-1:0] a_reg, a_next;
    logic [ncr_pkg::STEP_W-1:0]        iter_reg, iter_next;
    logic [1:0]                        reason_reg, reason_next;
    logic [ncr_pkg::A2_W-1:0]          a2_reg, a2_next;
    logic [ncr_pkg::PROD_W-1:0]        plo_reg, plo_next;
    logic signed [ncr_pkg::ERR_W-1:0]  err_reg, err_next;
    logic                              eneg_reg, eneg_next;

    logic [ncr_pkg::DATA_W-1:0]        mag;
    logic [ncr_pkg::DATA_W-1:0]        mul_a, mul_b;
    logic [ncr_pkg::PROD_W-1:0]        prod;
    logic [ncr_pkg::A2_W-1:0]          a2_w;
    logic [ncr_pkg::PROD_W+ncr_pkg::DATA_W-1:0] a3_full;
    logic [ncr_pkg::ERR_W-1:0]         a3_mag;
    logic signed [ncr_pkg::ERR_W-1:0]  a3_s;
    logic [ncr_pkg::ERR_W-1:0]         emag;
    logic                              div_start, div_done;
    logic [ncr_pkg::NUM_W-1:0]         div_num, quo;
    logic [ncr_pkg::DEN_W-1:0]         div_den;
    logic [ncr_pkg::CAP_BIT:0]         q_cap;
    logic signed [ncr_pkg::NA_W-1:0]   na;
    logic                              limit_stop;

    localparam logic signed [ncr_pkg::NA_W-1:0] NA_MAX =
        ncr_pkg::NA_W'({1'b0, {(ncr_pkg::DATA_W-1){1'b1}}});
    localparam logic signed [ncr_pkg::NA_W-1:0] NA_MIN = -NA_MAX - 1;

    ncr_mul u_mul
    (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    ncr_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (quo)
    );

    assign mag  = a_reg[ncr_pkg::DATA_W-1] ? (~a_reg + 1'b1) : a_reg;
    assign a2_w = prod[ncr_pkg::FRAC_BITS +: ncr_pkg::A2_W];
    assign a3_full = {{ncr_pkg::DATA_W{1'b0}}, plo_reg}
                   + {prod, {ncr_pkg::DATA_W{1'b0}}};
    assign a3_mag = a3_full[ncr_pkg::FRAC_BITS +: ncr_pkg::ERR_W];
    assign a3_s   = a_reg[ncr_pkg::DATA_W-1] ? -$signed(a3_mag) : $signed(a3_mag);
    assign emag   = err_reg[ncr_pkg::ERR_W-1] ? (~err_reg + 1'b1) : err_reg;
    assign div_num = {emag, {ncr_pkg::FRAC_BITS{1'b0}}};
    assign div_den = {2'b00, a2_reg} + {1'b0, a2_reg, 1'b0};

    // The quotient is clamped so the estimate update stays in a narrow adder.
    assign q_cap = (quo > ncr_pkg::NUM_W'(1) << ncr_pkg::CAP_BIT)
                 ? {1'b1, {ncr_pkg::CAP_BIT{1'b0}}} : quo[ncr_pkg::CAP_BIT:0];

    always_comb
    begin
        logic signed [ncr_pkg::NA_W-1:0] qs;
        qs = eneg_reg ? -$signed({2'b00, q_cap}) : $signed({2'b00, q_cap});
        na = ncr_pkg::NA_W'(a_reg) - qs;
    end

    always_comb
    begin
        state_next  = state_reg;
        x_next      = x_reg;
        a_next      = a_reg;
        iter_next   = iter_reg;
        reason_next = reason_reg;
        a2_next     = a2_reg;
        plo_next    = plo_reg;
        err_next    = err_reg;
        eneg_next   = eneg_reg;
        mul_a       = mag;
        mul_b       = mag;
        div_start   = 1'b0;
        case (state_reg)
            ncr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    x_next      = value;
                    a_next      = ncr_pkg::DATA_W'(1) << ncr_pkg::FRAC_BITS;
                    iter_next   = '0;
                    reason_next = ncr_pkg::STOP_TOL;
                    if (value == '0)
                    begin
                        a_next     = '0;
                        state_next = ncr_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = ncr_pkg::ST_SQ;
                    end
                end
            end
            ncr_pkg::ST_SQ:
            begin
                state_next = ncr_pkg::ST_LO;
            end
            ncr_pkg::ST_LO:
            begin
                a2_next    = a2_w;
                mul_a      = a2_w[ncr_pkg::A2_LO_W-1:0];
                state_next = ncr_pkg::ST_HI;
            end
            ncr_pkg::ST_HI:
            begin
                mul_a      = ncr_pkg::DATA_W'(a2_reg[ncr_pkg::A2_W-1 -: ncr_pkg::A2_HI_W]);
                plo_next   = prod;
                state_next = ncr_pkg::ST_SUM;
            end
            ncr_pkg::ST_SUM:
            begin
                err_next   = a3_s - ncr_pkg::ERR_W'(x_reg);
                state_next = ncr_pkg::ST_CHECK;
            end
            ncr_pkg::ST_CHECK:
            begin
                eneg_next = err_reg[ncr_pkg::ERR_W-1];
                if (emag < ncr_pkg::ERR_W'(tol_reg))
                begin
                    reason_next = ncr_pkg::STOP_TOL;
                    state_next  = ncr_pkg::ST_DONE;
                end
                else if (iter_reg > ncr_pkg::STEP_W'(lim_reg))
                begin
                    reason_next = ncr_pkg::STOP_LIMIT;
                    state_next  = ncr_pkg::ST_DONE;
                end
                else if (a2_reg == '0)
                begin
                    reason_next = ncr_pkg::STOP_FAULT;
                    state_next  = ncr_pkg::ST_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ncr_pkg::ST_DIV;
                end
            end
            ncr_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ncr_pkg::ST_UPD;
                end
            end
            ncr_pkg::ST_UPD:
            begin
                if (na > NA_MAX)
                begin
                    a_next = NA_MAX[ncr_pkg::DATA_W-1:0];
                end
                else if (na < NA_MIN)
                begin
                    a_next = NA_MIN[ncr_pkg::DATA_W-1:0];
                end
                else
                begin
                    a_next = na[ncr_pkg::DATA_W-1:0];
                end
                iter_next  = iter_reg + 1'b1;
                state_next = ncr_pkg::ST_SQ;
            end
            ncr_pkg::ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = ncr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ncr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ncr_pkg::ST_IDLE;
            tol_reg   <= ncr_pkg::TOL_W'(66);
            lim_reg   <= ncr_pkg::LIM_W'(20);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_index == ncr_pkg::CFG_TOLERANCE)
            begin
                tol_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == ncr_pkg::CFG_ITER_LIMIT)
            begin
                lim_reg <= cfg_data[ncr_pkg::LIM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        a_reg      <= a_next;
        iter_reg   <= iter_next;
        reason_reg <= reason_next;
        a2_reg     <= a2_next;
        plo_reg    <= plo_next;
        err_reg    <= err_next;
        eneg_reg   <= eneg_next;
    end

    assign in_ready    = (state_reg == ncr_pkg::ST_IDLE);
    assign out_valid   = (state_reg == ncr_pkg::ST_DONE);
    assign cfg_ready   = 1'b1;
    assign root        = a_reg;
    assign steps_taken = iter_reg;
    assign stop_reason = reason_reg;
    assign limit_stop  = out_valid && (stop_reason == ncr_pkg::STOP_LIMIT);

    `NCR_ASSERT_NOW(a_out_blocks_in, out_valid, !in_ready)
    `NCR_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready)
    `NCR_ASSERT_NOW(a_reason_code, out_valid, stop_reason <= ncr_pkg::STOP_FAULT)
    `NCR_ASSERT_NOW(a_limit_count, limit_stop, steps_taken > ncr_pkg::STEP_W'(lim_reg))
endmodule

// ----- hdl/ncr_mul.sv -----
// Shared unsigned 32x32 multiplier with a registered product.
// Depends on ncr_pkg.
`timescale 1ns / 1ps
module ncr_mul
(
    input  logic                          clk,
    input  logic [ncr_pkg::DATA_W-1:0]    op_a,
    input  logic [ncr_pkg::DATA_W-1:0]    op_b,
    output logic [ncr_pkg::PROD_W-1:0]    prod
);
    logic [ncr_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= {{ncr_pkg::DATA_W{1'b0}}, op_a} * {{ncr_pkg::DATA_W{1'b0}}, op_b};
    end

    assign prod = prod_reg;
endmodule

// ----- hdl/ncr_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on ncr_pkg.
`timescale 1ns / 1ps
module ncr_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ncr_pkg::NUM_W-1:0]     num,
    input  logic [ncr_pkg::DEN_W-1:0]     den,
    output logic                          done,
    output logic [ncr_pkg::NUM_W-1:0]     quo
);
    logic [ncr_pkg::DEN_W:0]    rem_reg, rem_next;
    logic [ncr_pkg::NUM_W-1:0]  quo_reg, quo_next;
    logic [ncr_pkg::DEN_W-1:0]  den_reg;
    logic [ncr_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       done_reg, done_next;
    logic [ncr_pkg::DEN_W+1:0]  trial;
    logic [ncr_pkg::DEN_W+1:0]  diff;
    logic                       fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[ncr_pkg::NUM_W-1]};
        fits      = trial >= {2'b00, den_reg};
        diff      = trial - {2'b00, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = num;
            cnt_next = ncr_pkg::CNT_W'(ncr_pkg::NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next = fits ? diff[ncr_pkg::DEN_W:0] : trial[ncr_pkg::DEN_W:0];
            quo_next = {quo_reg[ncr_pkg::NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            done_next = (cnt_reg == ncr_pkg::CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for newton_cube_root_top: directed and random words, checked
// against a behavioral Newton cube root predictor. Depends on ncr_pkg and the RTL.
`timescale 1ns / 1ps
module testbench;
    typedef struct packed {
        logic signed [ncr_pkg::DATA_W-1:0] root;
        logic [ncr_pkg::STEP_W-1:0]        steps;
        logic [1:0]                        reason;
    } root_result_t;

    typedef struct {
        logic signed [ncr_pkg::DATA_W-1:0] value;
        bit                                known;
        root_result_t                      res;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [ncr_pkg::DATA_W-1:0] value;
    logic out_valid;
    logic out_ready;
    logic signed [ncr_pkg::DATA_W-1:0] root;
    logic [ncr_pkg::STEP_W-1:0] steps_taken;
    logic [1:0] stop_reason;
    logic cfg_valid;
    logic cfg_ready;
    logic [ncr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ncr_pkg::TOL_W-1:0] cfg_data;

    logic [ncr_pkg::TOL_W-1:0] tol_reg;
    logic [ncr_pkg::LIM_W-1:0] limit_reg;
    root_result_t pending_roots[$];
    int failures;
    int idle_cycles;
    bit no_gaps;

    newton_cube_root_top dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .value(value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .root(root),
        .steps_taken(steps_taken),
        .stop_reason(stop_reason),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic root_result_t cube_root_of(logic signed [ncr_pkg::DATA_W-1:0] v);
        longint x;
        longint est;
        longint q;
        int unsigned n;
        logic [1:0] why;
        logic [63:0] mag;
        logic [63:0] sq;
        logic [127:0] cube;
        logic [127:0] err;
        logic [127:0] emag;
        logic [127:0] quo;
        logic signed [127:0] xw;
        bit neg;
        root_result_t r;
        x = v;
        est = longint'(1) << ncr_pkg::FRAC_BITS;
        n = 0;
        if (x == 0)
        begin
            r.root = '0;
            r.steps = '0;
            r.reason = ncr_pkg::STOP_TOL;
            return r;
        end
        xw = x;
        while (1)
        begin
            mag = (est < 0) ? -est : est;
            sq = (mag * mag) >> ncr_pkg::FRAC_BITS;
            cube = ({64'd0, sq} * {64'd0, mag}) >> ncr_pkg::FRAC_BITS;
            if (est < 0)
                cube = -cube;
            err = cube - xw;
            neg = err[127];
            emag = neg ? -err : err;
            if (emag < {97'd0, tol_reg})
            begin
                why = ncr_pkg::STOP_TOL;
                break;
            end
            if (n > limit_reg)
            begin
                why = ncr_pkg::STOP_LIMIT;
                break;
            end
            if (sq == 0)
            begin
                why = ncr_pkg::STOP_FAULT;
                break;
            end
            quo = (emag << ncr_pkg::FRAC_BITS) / ({64'd0, sq} * 128'd3);
            if (quo > (128'd1 << ncr_pkg::CAP_BIT))
                quo = 128'd1 << ncr_pkg::CAP_BIT;
            q = longint'(quo[63:0]);
            if (neg)
                q = -q;
            est = est - q;
            if (est > 64'sd2147483647)
                est = 64'sd2147483647;
            if (est < -64'sd2147483648)
                est = -64'sd2147483648;
            n++;
        end
        r.root = est[ncr_pkg::DATA_W-1:0];
        r.steps = n[ncr_pkg::STEP_W-1:0];
        r.reason = why;
        return r;
    endfunction

    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 6);
    endfunction

    // Leaves in_valid high so back-to-back words need no second assignment.
    task automatic send_word(logic signed [ncr_pkg::DATA_W-1:0] v);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        value <= v;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        pending_roots.push_back(cube_root_of(v));
    endtask

    // Drains the block, then writes one register.
    task automatic write_reg(logic [ncr_pkg::CFG_IDX_W-1:0] idx,
                             logic [ncr_pkg::TOL_W-1:0] data);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_roots.size() != 0)
            @(negedge clk);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        if (idx == ncr_pkg::CFG_TOLERANCE)
            tol_reg = data;
        else
            limit_reg = data[ncr_pkg::LIM_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [ncr_pkg::DATA_W-1:0] random_value();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            2: return $signed($urandom_range(0, 1023)) - 512;
            default: return $urandom_range(0, 32'h0100_0000) << $urandom_range(0, 7);
        endcase
    endfunction

    // Result checker with random back-pressure.
    initial
    begin
        root_result_t want;
        int stall;
        out_ready = 1'b0;
        forever
        begin
            stall = draw_gap();
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && rst_n));
            if (pending_roots.size() == 0)
            begin
                $error("result word with none expected: root %0d", root);
                failures++;
            end
            else
            begin
                want = pending_roots.pop_front();
                if (root !== want.root)
                begin
                    $error("root: expected %0d, actual %0d", want.root, root);
                    failures++;
                end
                if (steps_taken !== want.steps)
                begin
                    $error("steps_taken: expected %0d, actual %0d", want.steps, steps_taken);
                    failures++;
                end
                if (stop_reason !== want.reason)
                begin
                    $error("stop_reason: expected %0d, actual %0d", want.reason, stop_reason);
                    failures++;
                end
            end
        end
    end

    // Watchdog: fails the run when the idle count since the last handshake passes its limit.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 200000)
        begin
            $display("FAIL newton_cube_root_top");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows[$];
        root_result_t got;
        int settle;
        rst_n = 1'b0;
        in_valid = 1'b0;
        value = '0;
        cfg_valid = 1'b0;
        cfg_index = ncr_pkg::CFG_TOLERANCE;
        cfg_data = '0;
        failures = 0;
        idle_cycles = 0;
        no_gaps = 1'b0;
        tol_reg = ncr_pkg::TOL_W'(66);
        limit_reg = ncr_pkg::LIM_W'(20);
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        rows.push_back('{32'sd0, 1'b1, '{32'sd0, 9'd0, ncr_pkg::STOP_TOL}});
        rows.push_back('{32'sd65536, 1'b1, '{32'sd65536, 9'd0, ncr_pkg::STOP_TOL}});
        rows.push_back('{32'sh7FFF_FFFF, 1'b0, '{0, 0, 0}});
        rows.push_back('{32'sh8000_0000, 1'b0, '{0, 0, 0}});
        rows.push_back('{32'sd1, 1'b0, '{0, 0, 0}});
        rows.push_back('{-32'sd1, 1'b0, '{0, 0, 0}});
        rows.push_back('{32'sd524288, 1'b0, '{0, 0, 0}});
        rows.push_back('{-32'sd524288, 1'b0, '{0, 0, 0}});
        rows.push_back('{-32'sd65536, 1'b0, '{0, 0, 0}});
        rows.push_back('{32'sd100, 1'b0, '{0, 0, 0}});
        rows.push_back('{32'sh5555_5555, 1'b0, '{0, 0, 0}});
        rows.push_back('{32'shAAAA_AAAA, 1'b0, '{0, 0, 0}});
        foreach (rows[i])
        begin
            if (rows[i].known)
            begin
                got = cube_root_of(rows[i].value);
                if (got !== rows[i].res)
                begin
                    $error("predictor: expected %p, actual %p", rows[i].res, got);
                    failures++;
                end
            end
            send_word(rows[i].value);
        end

        // Zero tolerance with the smallest and largest limits, then the largest tolerance.
        write_reg(ncr_pkg::CFG_TOLERANCE, '0);
        write_reg(ncr_pkg::CFG_ITER_LIMIT, '0);
        send_word(32'sd65536);
        send_word(32'sh8000_0000);
        send_word(32'sd3);
        write_reg(ncr_pkg::CFG_ITER_LIMIT, ncr_pkg::TOL_W'(255));
        send_word(32'sd1);
        send_word(-32'sd1);
        send_word(32'sh7FFF_FFFF);
        write_reg(ncr_pkg::CFG_TOLERANCE, 31'h7FFF_FFFF);
        send_word(32'sh8000_0000);
        send_word(32'sd12345);

        for (int phase = 0; phase < 6; phase++)
        begin
            no_gaps = (phase == 2);
            write_reg(ncr_pkg::CFG_TOLERANCE, ncr_pkg::TOL_W'(($urandom_range(0, 3) == 0)
                      ? $urandom() : $urandom_range(0, 200)));
            write_reg(ncr_pkg::CFG_ITER_LIMIT, ncr_pkg::TOL_W'($urandom_range(0, 30)));
            repeat (100) send_word(random_value());
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_roots.size() != 0)
            @(posedge clk);
        settle = 0;
        while (settle < 100)
        begin
            @(posedge clk);
            settle++;
        end
        if (failures == 0)
            $display("PASS newton_cube_root_top");
        else
            $display("FAIL newton_cube_root_top");
        $finish;
    end
endmodule
